// ===== sv/clnw_pkg.sv =====
// shared types, constants and helper functions for the character lcd nibble writer
`default_nettype none

package clnw_pkg;

    // widths of the stream and configuration ports
    localparam int unsigned HOLD_FIELD_W  = 24;
    localparam int unsigned CFG_INDEX_W   = 2;
    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned S_TUSER_W     = 2;
    localparam int unsigned M_TDATA_W     = 32;
    localparam int unsigned M_TUSER_W     = 1;

    // default width of the stored hold counts
    localparam int unsigned HOLD_WIDTH_DEF = 24;

    // job queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // phases of the init request
    localparam int unsigned INIT_PHASES = 26;
    localparam int unsigned STEP_W      = $clog2(INIT_PHASES);

    // register reset values
    localparam int unsigned PHASE_HOLD_RST = 300;
    localparam int unsigned POWER_UP_RST   = 15;
    localparam int unsigned SETTLE_RST     = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_HOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_UP   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE     = 2'd2;

    // request kinds
    localparam logic [1:0] OP_INIT     = 2'd0;
    localparam logic [1:0] OP_POSITION = 2'd1;
    localparam logic [1:0] OP_CHAR     = 2'd2;
    localparam logic [1:0] OP_RAW      = 2'd3;

    // cursor selection of a position request
    localparam logic [1:0] LINE_NONE = 2'd0;
    localparam logic [1:0] LINE_ONE  = 2'd1;
    localparam logic [1:0] LINE_TWO  = 2'd2;

    // command bytes
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_LINE_ONE = 8'h80;
    localparam logic [7:0] CMD_LINE_TWO = 8'hC0;
    localparam logic [7:0] CMD_WAKE     = 8'h03;
    localparam logic [7:0] CMD_4BIT     = 8'h02;
    localparam logic [7:0] CMD_FUNC_SET = 8'b0010_1000;
    localparam logic [7:0] CMD_DISP_ON  = 8'b0000_1100;
    localparam logic [7:0] CMD_ENTRY    = 8'b0000_0110;

    // phase positions inside the init sequence
    localparam logic [STEP_W-1:0] INIT_POWER_STEP  = STEP_W'(0);
    localparam logic [STEP_W-1:0] INIT_SETTLE_STEP = STEP_W'(5);
    localparam logic [STEP_W-1:0] INIT_TAIL_STEP   = STEP_W'(6);
    localparam logic [STEP_W-1:0] INIT_LAST_STEP   = STEP_W'(INIT_PHASES - 1);

    // which count a phase is held for
    typedef enum logic [1:0] {
        HOLD_NIBBLE,
        HOLD_POWER,
        HOLD_SETTLE
    } t_hold_sel;

    // classified request as it waits in the queue
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic       has_clear;
        logic       two_bytes;
        logic [7:0] cmd_byte;
    } t_job;

    // one phase of the init sequence
    typedef struct packed {
        logic       en;
        logic [3:0] nib;
        t_hold_sel  hsel;
    } t_init_phase;

    // commands sent after the settle wait
    function automatic logic [7:0] init_tail_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CMD_4BIT;
            3'd1:    b = CMD_FUNC_SET;
            3'd2:    b = CMD_DISP_ON;
            3'd3:    b = CMD_ENTRY;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

    // nibble of one of the four phases of a byte
    function automatic logic [3:0] byte_nibble(input logic [7:0] b, input logic [1:0] p);
        return p[1] ? b[3:0] : b[7:4];
    endfunction

    // phase table of the init request
    function automatic t_init_phase init_phase(input logic [STEP_W-1:0] step);
        t_init_phase     ph;
        logic [STEP_W-1:0] rel;
        logic [7:0]      b;
        logic [1:0]      p;
        rel = step - INIT_TAIL_STEP;
        b   = init_tail_byte(rel[4:2]);
        p   = rel[1:0];
        if (step == INIT_POWER_STEP) begin
            ph.en   = 1'b0;
            ph.nib  = 4'h0;
            ph.hsel = HOLD_POWER;
        end else if (step == INIT_SETTLE_STEP) begin
            ph.en   = 1'b0;
            ph.nib  = CMD_WAKE[3:0];
            ph.hsel = HOLD_SETTLE;
        end else if (step < INIT_SETTLE_STEP) begin
            p       = 2'(step - STEP_W'(1));
            ph.en   = ~p[0];
            ph.nib  = byte_nibble(CMD_WAKE, p);
            ph.hsel = HOLD_NIBBLE;
        end else begin
            ph.en   = ~p[0];
            ph.nib  = byte_nibble(b, p);
            ph.hsel = HOLD_NIBBLE;
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

// ===== sv/clnw_front.sv =====
// request decoder: classifies incoming requests into queue jobs
`default_nettype none

module clnw_front (
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [clnw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [clnw_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                o_push,
    output clnw_pkg::t_job                      o_job,
    input  wire logic                           i_full
);

    logic       clear_first;
    logic [1:0] line_select;
    logic [7:0] byte_value;
    logic       has_cursor;
    logic       empty_req;

    assign clear_first = s_axis_tdata[0];
    assign line_select = s_axis_tdata[2:1];
    assign byte_value  = s_axis_tdata[10:3];

    assign s_axis_tready = ~i_full;

    // line select 3 means no cursor move
    assign has_cursor = (line_select == clnw_pkg::LINE_ONE) ||
                        (line_select == clnw_pkg::LINE_TWO);

    always_comb begin
        o_job     = '0;
        empty_req = 1'b0;
        unique case (s_axis_tuser)
            clnw_pkg::OP_INIT: begin
                o_job.is_init = 1'b1;
            end
            clnw_pkg::OP_POSITION: begin
                o_job.has_clear = clear_first;
                o_job.two_bytes = clear_first & has_cursor;
                o_job.cmd_byte  = (line_select == clnw_pkg::LINE_TWO) ?
                                  clnw_pkg::CMD_LINE_TWO : clnw_pkg::CMD_LINE_ONE;
                empty_req       = ~clear_first & ~has_cursor;
            end
            clnw_pkg::OP_CHAR: begin
                o_job.rs       = 1'b1;
                o_job.cmd_byte = byte_value;
            end
            default: begin
                o_job.cmd_byte = byte_value;
            end
        endcase
    end

    // a position request with nothing to do is taken and dropped
    assign o_push = s_axis_tvalid & ~i_full & ~empty_req & i_rst_n;

endmodule

`default_nettype wire

// ===== sv/clnw_queue.sv =====
// small job queue between the request decoder and the phase sequencer
`default_nettype none

module clnw_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire clnw_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output clnw_pkg::t_job      o_job,
    output logic                o_empty
);

    localparam int unsigned PTR_W = $clog2(clnw_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(clnw_pkg::QUEUE_DEPTH + 1);

    clnw_pkg::t_job    r_mem [clnw_pkg::QUEUE_DEPTH];
    clnw_pkg::t_job    r_head_job;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(clnw_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    // popped job, held until the next pop
    assign o_job   = r_head_job;

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(clnw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(clnw_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (do_pop) begin
            r_head_job <= r_mem[r_rd_ptr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/clnw_back.sv =====
// phase sequencer: expands queued jobs into bus phases and holds the timing registers
`default_nettype none

module clnw_back #(
    parameter int unsigned HOLD_WIDTH = clnw_pkg::HOLD_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [clnw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [clnw_pkg::HOLD_FIELD_W-1:0] i_cfg_data,
    input  wire clnw_pkg::t_job                   i_job,
    input  wire logic                             i_empty,
    output logic                                  o_pop,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [clnw_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic [clnw_pkg::M_TUSER_W-1:0]        m_axis_tuser,
    output logic                                  m_axis_tlast
);

    localparam int unsigned STEP_W = clnw_pkg::STEP_W;
    localparam int unsigned HF_W   = clnw_pkg::HOLD_FIELD_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state               r_state;
    logic [STEP_W-1:0]    r_step;
    logic [HOLD_WIDTH-1:0] r_phase_hold, r_power_up, r_settle;

    logic                 r_out_valid;
    logic                 r_out_rs, r_out_en, r_out_last;
    logic [3:0]           r_out_nib;
    logic [HF_W-1:0]      r_out_hold;

    clnw_pkg::t_init_phase iph;
    logic                  ph_en, ph_last;
    logic [3:0]            ph_nib;
    clnw_pkg::t_hold_sel   ph_hsel;
    logic [7:0]            cur_byte;
    logic [HOLD_WIDTH-1:0] ph_hold;
    logic                  advance;

    // current phase from job and step; the queue holds the job until the next pop
    always_comb begin
        iph      = clnw_pkg::init_phase(r_step);
        cur_byte = (i_job.has_clear && !r_step[2]) ? clnw_pkg::CMD_CLEAR : i_job.cmd_byte;
        if (i_job.is_init) begin
            ph_en   = iph.en;
            ph_nib  = iph.nib;
            ph_hsel = iph.hsel;
            ph_last = (r_step == clnw_pkg::INIT_LAST_STEP);
        end else begin
            ph_en   = ~r_step[0];
            ph_nib  = clnw_pkg::byte_nibble(cur_byte, r_step[1:0]);
            ph_hsel = clnw_pkg::HOLD_NIBBLE;
            ph_last = (r_step[1:0] == 2'd3) && (!i_job.two_bytes || r_step[2]);
        end
        unique case (ph_hsel)
            clnw_pkg::HOLD_POWER:  ph_hold = r_power_up;
            clnw_pkg::HOLD_SETTLE: ph_hold = r_settle;
            default:               ph_hold = r_phase_hold;
        endcase
    end

    assign advance = (r_state == ST_RUN) && (!r_out_valid || m_axis_tready);
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_RUN;
                        r_step  <= '0;
                    end
                end
                default: begin
                    if (advance) begin
                        r_step <= r_step + 1'b1;
                        if (ph_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
            endcase
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out_rs    <= i_job.rs;
                r_out_en    <= ph_en;
                r_out_nib   <= ph_nib;
                r_out_hold  <= HF_W'(ph_hold);
                r_out_last  <= ph_last;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_hold <= HOLD_WIDTH'(clnw_pkg::PHASE_HOLD_RST);
            r_power_up   <= HOLD_WIDTH'(clnw_pkg::POWER_UP_RST);
            r_settle     <= HOLD_WIDTH'(clnw_pkg::SETTLE_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                clnw_pkg::CFG_PHASE_HOLD: r_phase_hold <= HOLD_WIDTH'(i_cfg_data);
                clnw_pkg::CFG_POWER_UP:   r_power_up   <= HOLD_WIDTH'(i_cfg_data);
                clnw_pkg::CFG_SETTLE:     r_settle     <= HOLD_WIDTH'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_rs;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(clnw_pkg::M_TDATA_W - HF_W - 5){1'b0}},
                            r_out_hold, r_out_nib, r_out_en};

endmodule

`default_nettype wire

// ===== sv/char_lcd_nibble_writer.sv =====
// top level of the character lcd nibble writer
`default_nettype none

// Turns requests into pin phases for a character LCD on a 4-bit bus. Each
// result transfer is one phase: register select (tuser), enable level, data
// nibble and hold time in ticks (tdata), with tlast on the final phase of the
// request. Every byte becomes four phases (enable high/low with the upper
// nibble, then enable high/low with the lower nibble). Request kinds: init
// (power-up wait, 0x03, settle wait, 0x02 0x28 0x0C 0x06 0x01, 26 phases),
// position (optional clear, then cursor 0x80 or 0xC0; a position with neither
// gives no phases), character (rs 1) and raw command (rs 0). A decoder takes
// requests into a four-entry job queue; a sequencer behind it sends one phase
// per cycle while the output is free, and loads each job from an idle state
// before its first phase. The hold registers are written through the config
// port and should only change while no phases are pending; they are kept to
// HOLD_WIDTH bits.
module char_lcd_nibble_writer #(
    parameter int unsigned HOLD_WIDTH = clnw_pkg::HOLD_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [0] clear_first, [2:1] line_select, [10:3] byte_value, rest zero
    input  wire logic [clnw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] operation
    input  wire logic [clnw_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // phase stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] enable, [4:1] bus_nibble, [28:5] hold_ticks, rest zero
    output logic [clnw_pkg::M_TDATA_W-1:0]         m_axis_tdata,
    // [0] register_select
    output logic [clnw_pkg::M_TUSER_W-1:0]         m_axis_tuser,
    output logic                                   m_axis_tlast,
    // config write port: 0 phase hold, 1 power-up wait, 2 settle wait
    input  wire logic                              i_cfg_we,
    input  wire logic [clnw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [clnw_pkg::HOLD_FIELD_W-1:0] i_cfg_data
);

    // decoder to queue
    logic           push;
    logic           full;
    clnw_pkg::t_job push_job;

    // queue to sequencer
    logic           pop;
    logic           empty;
    clnw_pkg::t_job head_job;

    clnw_front u_front (
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (push),
        .o_job         (push_job),
        .i_full        (full)
    );

    clnw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    // sequencer owns the timing registers and the output register
    clnw_back #(
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_job         (head_job),
        .i_empty       (empty),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== bench/lcd_phase_checker.sv =====
// checker for the lcd nibble writer: predicts bus phases from requests and compares them
`default_nettype none

module lcd_phase_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [clnw_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  wire logic [clnw_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [clnw_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic [clnw_pkg::M_TUSER_W-1:0]    m_axis_tuser,
    input  wire logic                              m_axis_tlast,
    input  wire logic                              i_cfg_we,
    input  wire logic [clnw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [clnw_pkg::HOLD_FIELD_W-1:0] i_cfg_data,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import clnw_pkg::*;

    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic                    rs;
        logic                    en;
        logic [3:0]              nib;
        logic [HOLD_FIELD_W-1:0] hold;
        logic                    last;
    } t_lcd_phase;

    t_lcd_phase expected_phases[$];
    logic [HOLD_FIELD_W-1:0] nibble_hold;
    logic [HOLD_FIELD_W-1:0] power_up_hold;
    logic [HOLD_FIELD_W-1:0] settle_hold;
    int fails = 0;

    function automatic t_lcd_phase make_phase(input logic rs, input logic en,
                                              input logic [3:0] nib,
                                              input logic [HOLD_FIELD_W-1:0] hold,
                                              input logic last);
        t_lcd_phase ph;
        ph.rs   = rs;
        ph.en   = en;
        ph.nib  = nib;
        ph.hold = hold;
        ph.last = last;
        return ph;
    endfunction

    // expand one request into its bus phases
    task automatic predict_phases(input logic [1:0] op, input logic clr,
                                  input logic [1:0] line, input logic [7:0] val);
        logic [7:0] bytes[6];
        int         nbytes;
        int         total;
        int         k;
        logic       rs;
        logic       is_init;
        logic [3:0] nib;
        nbytes  = 0;
        rs      = 1'b0;
        is_init = (op == OP_INIT);
        case (op)
            OP_INIT: begin
                bytes[0] = CMD_WAKE;
                bytes[1] = CMD_4BIT;
                bytes[2] = CMD_FUNC_SET;
                bytes[3] = CMD_DISP_ON;
                bytes[4] = CMD_ENTRY;
                bytes[5] = CMD_CLEAR;
                nbytes   = 6;
            end
            OP_POSITION: begin
                if (clr) begin
                    bytes[nbytes] = CMD_CLEAR;
                    nbytes++;
                end
                if (line == LINE_ONE) begin
                    bytes[nbytes] = CMD_LINE_ONE;
                    nbytes++;
                end else if (line == LINE_TWO) begin
                    bytes[nbytes] = CMD_LINE_TWO;
                    nbytes++;
                end
            end
            OP_CHAR: begin
                bytes[0] = val;
                nbytes   = 1;
                rs       = 1'b1;
            end
            default: begin
                bytes[0] = val;
                nbytes   = 1;
            end
        endcase
        total = nbytes * 4 + (is_init ? 2 : 0);
        k = 0;
        if (is_init) begin
            expected_phases.push_back(make_phase(1'b0, 1'b0, 4'h0, power_up_hold,
                                                 k == total - 1));
            k++;
        end
        for (int b = 0; b < nbytes; b++) begin
            for (int p = 0; p < 4; p++) begin
                nib = (p >= 2) ? bytes[b][3:0] : bytes[b][7:4];
                expected_phases.push_back(make_phase(rs, (p % 2) == 0, nib, nibble_hold,
                                                     k == total - 1));
                k++;
            end
            // settle wait keeps the wake nibble on the bus
            if (is_init && b == 0) begin
                expected_phases.push_back(make_phase(1'b0, 1'b0, CMD_WAKE[3:0],
                                                     settle_hold, k == total - 1));
                k++;
            end
        end
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        if (fails < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        fails++;
    endtask

    task automatic check_phase();
        t_lcd_phase want;
        if (expected_phases.size() == 0) begin
            if (fails < MAX_REPORTS)
                $display("%0t: unexpected phase, expected none, actual %0h", $time,
                         m_axis_tdata);
            fails++;
        end else begin
            want = expected_phases.pop_front();
            if (m_axis_tuser[0] !== want.rs)
                report("register_select", 32'(want.rs), 32'(m_axis_tuser[0]));
            if (m_axis_tdata[0] !== want.en)
                report("enable", 32'(want.en), 32'(m_axis_tdata[0]));
            if (m_axis_tdata[4:1] !== want.nib)
                report("bus_nibble", 32'(want.nib), 32'(m_axis_tdata[4:1]));
            if (m_axis_tdata[28:5] !== want.hold)
                report("hold_ticks", 32'(want.hold), 32'(m_axis_tdata[28:5]));
            if (m_axis_tlast !== want.last)
                report("last", 32'(want.last), 32'(m_axis_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            nibble_hold   <= HOLD_FIELD_W'(PHASE_HOLD_RST);
            power_up_hold <= HOLD_FIELD_W'(POWER_UP_RST);
            settle_hold   <= HOLD_FIELD_W'(SETTLE_RST);
            expected_phases.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PHASE_HOLD: nibble_hold   <= i_cfg_data;
                    CFG_POWER_UP:   power_up_hold <= i_cfg_data;
                    CFG_SETTLE:     settle_hold   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_phases(s_axis_tuser[1:0], s_axis_tdata[0], s_axis_tdata[2:1],
                               s_axis_tdata[10:3]);
            if (m_axis_tvalid && m_axis_tready)
                check_phase();
        end
        o_pending    <= expected_phases.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// top of the lcd nibble writer testbench: clock, reset, stimulus and verdict
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clnw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_WAIT  = 40;   // margin after the last expected phase
    localparam int STALL_CYCLES = 400;  // long receiver hold-off, enough to fill the job queue
    localparam int ITEMS_PER_PHASE = 150;
    localparam logic [HOLD_FIELD_W-1:0] HOLD_MAX = '1;
    localparam logic [CFG_INDEX_W-1:0]  CFG_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // request side
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [0] clear_first, [2:1] line_select, [10:3] byte_value, [15:11] zero
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // [1:0] operation
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;

    // phase side
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [0] enable, [4:1] bus_nibble, [28:5] hold_ticks, [31:29] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] register_select
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    // config write port
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [HOLD_FIELD_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int pending_phases;

    // idle percentages, set by the stimulus per phase of the run
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    // long receiver hold-off request and its own countdown
    logic pressure_arm   = 1'b0;
    logic pressure_fired = 1'b0;
    int   rx_hold_left   = 0;
    int   cycle_count    = 0;

    char_lcd_nibble_writer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    lcd_phase_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_phases)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // phase receiver: random stalls, plus one long hold-off once armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (pressure_arm && !pressure_fired) begin
            pressure_fired = 1'b1;
            rx_hold_left   = STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // offer one request and wait for its transfer; random gaps go in front
    task automatic send_req(input logic [1:0] op, input logic clr, input logic [1:0] line,
                            input logic [7:0] val);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, val, line, clr};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // wait for every expected phase, then a settle margin
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_phases != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // write all hold registers plus the unused index; only while idle
    task automatic set_holds(input logic [HOLD_FIELD_W-1:0] nibble,
                             input logic [HOLD_FIELD_W-1:0] power_up,
                             input logic [HOLD_FIELD_W-1:0] settle);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PHASE_HOLD;
        i_cfg_data  <= nibble;
        @(posedge i_clk);
        i_cfg_index <= CFG_POWER_UP;
        i_cfg_data  <= power_up;
        @(posedge i_clk);
        i_cfg_index <= CFG_SETTLE;
        i_cfg_data  <= settle;
        @(posedge i_clk);
        // unknown index must leave every register alone
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= HOLD_FIELD_W'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // random traffic; empty positions do not count toward the item total
    task automatic random_traffic(input int n_items);
        logic [1:0] op;
        logic       clr;
        logic [1:0] line;
        int         sent;
        int         pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 10)      op = OP_INIT;
            else if (pick < 40) op = OP_POSITION;
            else if (pick < 70) op = OP_CHAR;
            else                op = OP_RAW;
            clr  = 1'($urandom_range(1));
            line = 2'($urandom_range(3));
            send_req(op, clr, line, 8'($urandom_range(255)));
            if (!(op == OP_POSITION && !clr && (line == LINE_NONE || line == 2'd3)))
                sent++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset hold values, no idling
        send_req(OP_INIT, 1'b0, LINE_NONE, 8'h00);
        send_req(OP_POSITION, 1'b0, LINE_NONE, 8'hFF);   // empty position
        send_req(OP_POSITION, 1'b1, LINE_NONE, 8'h00);
        send_req(OP_POSITION, 1'b0, LINE_ONE, 8'h00);
        send_req(OP_POSITION, 1'b0, LINE_TWO, 8'hFF);
        send_req(OP_POSITION, 1'b1, LINE_ONE, 8'h00);
        send_req(OP_POSITION, 1'b1, LINE_TWO, 8'h00);
        send_req(OP_POSITION, 1'b0, 2'd3, 8'h00);        // unused line select, empty
        send_req(OP_POSITION, 1'b1, 2'd3, 8'hAA);        // unused line select after clear
        send_req(OP_CHAR, 1'b1, 2'd3, 8'h00);            // unused fields set
        send_req(OP_CHAR, 1'b0, LINE_NONE, 8'hFF);
        send_req(OP_CHAR, 1'b0, LINE_ONE, 8'hA5);
        send_req(OP_RAW, 1'b0, LINE_NONE, 8'h00);
        send_req(OP_RAW, 1'b1, LINE_TWO, 8'hFF);
        send_req(OP_RAW, 1'b0, LINE_NONE, 8'h5A);
        send_req(OP_INIT, 1'b1, 2'd3, 8'hFF);
        drain();

        // hold extremes
        set_holds('0, '0, '0);
        send_req(OP_INIT, 1'b0, LINE_NONE, 8'h00);
        send_req(OP_CHAR, 1'b0, LINE_NONE, 8'h3C);
        drain();
        set_holds(HOLD_MAX, HOLD_MAX, HOLD_MAX);
        send_req(OP_INIT, 1'b0, LINE_NONE, 8'h00);
        send_req(OP_RAW, 1'b0, LINE_NONE, 8'hFF);
        send_req(OP_POSITION, 1'b1, LINE_TWO, 8'h00);
        drain();

        // slow sender side idles a little, receiver stalls a lot
        set_holds(HOLD_FIELD_W'($urandom), HOLD_FIELD_W'($urandom),
                  HOLD_FIELD_W'($urandom));
        tx_gap_pct   = 20;
        rx_stall_pct = 75;
        random_traffic(ITEMS_PER_PHASE);
        drain();

        // the other way round
        set_holds(HOLD_FIELD_W'($urandom_range(1023)), HOLD_FIELD_W'($urandom),
                  HOLD_FIELD_W'($urandom_range(15)));
        tx_gap_pct   = 75;
        rx_stall_pct = 20;
        random_traffic(ITEMS_PER_PHASE);
        drain();

        // full rate, starting with a long receiver hold-off to back up the queue
        set_holds(HOLD_FIELD_W'($urandom), HOLD_FIELD_W'($urandom),
                  HOLD_FIELD_W'($urandom));
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        pressure_arm = 1'b1;
        random_traffic(ITEMS_PER_PHASE);
        drain();

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
